// ----- sv/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int DEF_MAX_RUNS = 64;

  localparam int ADDR_W  = 48;
  localparam int BYTES_W = 32;
  localparam int REG_W   = 17;
  localparam int START_W = 16;
  localparam int LEN_W   = 17;
  localparam int DIV_CW  = 6;

  localparam logic [REG_W-1:0]  RST_BLOCK_BYTES  = 17'd256;
  localparam logic [REG_W-1:0]  RST_TOTAL_BLOCKS = 17'd16384;
  localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS = 48'd0;

  localparam logic [REG_W-1:0] RANGE_MAX = 17'd65536;

  // register indexes
  localparam logic [1:0] REG_BLOCK_BYTES  = 2'd0;
  localparam logic [1:0] REG_TOTAL_BLOCKS = 2'd1;
  localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } entry_t;

  // clamp a register value into 1..65536
  function automatic logic [REG_W-1:0] eff_range(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    if (v == '0) begin
      r = 17'd1;
    end else if (v > RANGE_MAX) begin
      r = RANGE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- sv/ffba_mem.sv -----
// ----------------------------------------------------------------------------
// ffba_mem
// Run table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_mem #(
  parameter int DEPTH = ffba_pkg::DEF_MAX_RUNS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ffba_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ffba_pkg::entry_t         rdata
);
  import ffba_pkg::*;

  entry_t ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= ram[raddr];
  end

endmodule

// ----- sv/ffba_div.sv -----
// ----------------------------------------------------------------------------
// ffba_div
// Restoring divider, one quotient bit per cycle, 48-bit by 17-bit.
// ----------------------------------------------------------------------------
module ffba_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ffba_pkg::ADDR_W-1:0]     numer,
  input  logic [ffba_pkg::REG_W-1:0]      denom,
  output logic                            done,
  output logic [ffba_pkg::ADDR_W-1:0]     quot
);
  import ffba_pkg::*;

  localparam logic [DIV_CW-1:0] LAST = DIV_CW'(ADDR_W - 1);

  logic              run;
  logic [DIV_CW-1:0] cnt;
  logic [REG_W-1:0]  rem;
  logic [REG_W-1:0]  d;
  logic [REG_W:0]    t;
  logic              ge;

  assign t  = {rem, quot[ADDR_W-1]};
  assign ge = t >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + DIV_CW'(1);
        if (cnt == LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= numer;
      rem  <= '0;
      d    <= denom;
    end else if (run) begin
      quot <= {quot[ADDR_W-2:0], ge};
      rem  <= ge ? REG_W'(t - {1'b0, d}) : t[REG_W-1:0];
    end
  end

endmodule

// ----- sv/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a sorted table of free block runs with merging.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_stall with cmd, request_bytes and
//   free_address; each transfer yields exactly one response on
//   rsp_valid/rsp_stall carrying status and granted_address.
//   The block works on one request at a time. Sizes and addresses are
//   turned into blocks by a shared bit-serial divider. An allocate that
//   fits the region then walks the run table in the memory and, on
//   emptying a run, shifts the tail down. A free does two divisions (one
//   if its address lies below the base address); an accepted free then
//   does a position search, a shift-up and one merge pass over the table.
//   The table memory has a single read port. After reset the block writes
//   the initial run (the whole region) in S_INIT before it takes a
//   request. Writing total_blocks rebuilds the table the same way. A
//   finished response waits in the output register while the receiver
//   stalls; a new request may transfer meanwhile, and its own response
//   waits for the register to drain.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int MAX_RUNS = ffba_pkg::DEF_MAX_RUNS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]   cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          cmd,
  input  logic [ffba_pkg::BYTES_W-1:0]  request_bytes,
  input  logic [ffba_pkg::ADDR_W-1:0]   free_address,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic [ffba_pkg::ADDR_W-1:0]   granted_address
);
  import ffba_pkg::*;

  localparam int AW = $clog2(MAX_RUNS);
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam logic [CW-1:0] RUNS_FULL = CW'(MAX_RUNS);
  localparam logic [CW-1:0] ONE = CW'(1);

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DIVN    = 5'd2;
  localparam logic [4:0] S_DIVH    = 5'd3;
  localparam logic [4:0] S_ASCAN   = 5'd4;
  localparam logic [4:0] S_AEVAL   = 5'd5;
  localparam logic [4:0] S_SHDN_RD = 5'd6;
  localparam logic [4:0] S_SHDN_WR = 5'd7;
  localparam logic [4:0] S_AADDR   = 5'd8;
  localparam logic [4:0] S_FIND_RD = 5'd9;
  localparam logic [4:0] S_FIND_EV = 5'd10;
  localparam logic [4:0] S_SHUP    = 5'd11;
  localparam logic [4:0] S_SHUP_WR = 5'd12;
  localparam logic [4:0] S_MRG0    = 5'd13;
  localparam logic [4:0] S_MRG1    = 5'd14;
  localparam logic [4:0] S_MRG_RD  = 5'd15;
  localparam logic [4:0] S_MRG_EV  = 5'd16;
  localparam logic [4:0] S_DONE    = 5'd17;

  logic [4:0] state;

  // configuration
  logic [REG_W-1:0]  block_bytes;
  logic [REG_W-1:0]  total_blocks;
  logic [ADDR_W-1:0] base_address;
  logic [REG_W-1:0]  eff_bb;
  logic [REG_W-1:0]  eff_tb;

  // request context
  logic               cmd_r;
  logic [ADDR_W-1:0]  faddr_r;
  logic [32:0]        cnt_r;
  logic [START_W-1:0] head_r;
  logic [32:0]        prod;
  logic [1:0]         st_r;
  logic [ADDR_W-1:0]  addr_r;

  // table walk
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] w;
  logic [CW-1:0] pos;
  entry_t        cur;

  // memory and divider hookup
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic              div_start;
  logic [ADDR_W-1:0] div_numer;
  logic              div_done;
  logic [ADDR_W-1:0] div_quot;

  // datapath terms
  logic              req_xfer;
  logic [32:0]       ceil_numer;
  logic              hit;
  logic [LEN_W-1:0]  new_len;
  logic [17:0]       new_start;
  logic              drop_run;
  logic              adjacent;
  logic [17:0]       len_sum;
  logic [LEN_W-1:0]  merged_len;
  logic              free_in_range;

  assign eff_bb = eff_range(block_bytes);
  assign eff_tb = eff_range(total_blocks);

  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;

  // round a byte count up to whole blocks
  assign ceil_numer = {1'b0, request_bytes} + {16'd0, eff_bb} - 33'd1;

  assign hit       = mem_rdata.len >= cnt_r[LEN_W-1:0];
  assign new_len   = mem_rdata.len - cnt_r[LEN_W-1:0];
  assign new_start = {2'b00, mem_rdata.start} + {1'b0, cnt_r[LEN_W-1:0]};
  assign drop_run  = (new_len == '0) || (new_start[17:16] != 2'b00);

  assign adjacent   = ({2'b00, cur.start} + {1'b0, cur.len}) == {2'b00, mem_rdata.start};
  assign len_sum    = {1'b0, cur.len} + {1'b0, mem_rdata.len};
  assign merged_len = len_sum[17] ? '1 : len_sum[LEN_W-1:0];

  // drop a free of zero blocks, or one that lies outside the region or spans past its end
  assign free_in_range = (div_quot < {31'd0, eff_tb}) && (cnt_r != '0) &&
                         (({1'b0, div_quot} + {16'd0, cnt_r}) <= {32'd0, eff_tb});

  ffba_mem #(
    .DEPTH(MAX_RUNS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ffba_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .numer(div_numer),
    .denom(eff_bb),
    .done (div_done),
    .quot (div_quot)
  );

  // Memory and divider control. Shift and merge steps read one entry, then
  // write a different entry; an allocate rewrites the run it just read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    div_start = 1'b0;
    div_numer = '0;
    if (cfg_we && cfg_index == REG_TOTAL_BLOCKS) begin
      // rebuild the table as one run over the whole region
      mem_we    = 1'b1;
      mem_wdata = '{start: '0, len: eff_range(cfg_data[REG_W-1:0])};
    end else begin
      case (state)
        S_INIT: begin
          mem_we    = 1'b1;
          mem_wdata = '{start: '0, len: eff_tb};
        end
        S_ASCAN, S_FIND_RD: begin
          mem_raddr = i[AW-1:0];
        end
        S_AEVAL: begin
          if (hit && !drop_run) begin
            mem_we    = 1'b1;
            mem_waddr = i[AW-1:0];
            mem_wdata = '{start: new_start[START_W-1:0], len: new_len};
          end
        end
        S_SHDN_RD: begin
          mem_raddr = j[AW-1:0];
        end
        S_SHDN_WR: begin
          mem_we    = 1'b1;
          mem_waddr = AW'(j - ONE);
          mem_wdata = mem_rdata;
        end
        S_SHUP: begin
          if (j == pos) begin
            mem_we    = 1'b1;
            mem_waddr = pos[AW-1:0];
            mem_wdata = '{start: head_r, len: cnt_r[LEN_W-1:0]};
          end else begin
            mem_raddr = AW'(j - ONE);
          end
        end
        S_SHUP_WR: begin
          mem_we    = 1'b1;
          mem_waddr = j[AW-1:0];
          mem_wdata = mem_rdata;
        end
        S_MRG_RD: begin
          if (i == count) begin
            mem_we    = 1'b1;
            mem_waddr = w[AW-1:0];
            mem_wdata = cur;
          end else begin
            mem_raddr = i[AW-1:0];
          end
        end
        S_MRG_EV: begin
          if (!adjacent) begin
            mem_we    = 1'b1;
            mem_waddr = w[AW-1:0];
            mem_wdata = cur;
          end
        end
        default: begin
        end
      endcase
      if (state == S_IDLE && req_valid) begin
        div_start = 1'b1;
        div_numer = {15'd0, ceil_numer};
      end else if (state == S_DIVN && div_done && cmd_r == CMD_FREE &&
                   faddr_r >= base_address) begin
        div_start = 1'b1;
        div_numer = faddr_r - base_address;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      count        <= ONE;
      block_bytes  <= RST_BLOCK_BYTES;
      total_blocks <= RST_TOTAL_BLOCKS;
      base_address <= RST_BASE_ADDRESS;
      rsp_valid    <= 1'b0;
    end else begin
      // load a finished response, or drop the one the receiver just took
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_xfer) begin
            cmd_r   <= cmd;
            faddr_r <= free_address;
            st_r    <= ST_OK;
            addr_r  <= '0;
            state   <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            cnt_r <= div_quot[32:0];
            if (cmd_r == CMD_ALLOC) begin
              if (div_quot > {31'd0, eff_tb}) begin
                st_r  <= ST_NO_SPACE;
                state <= S_DONE;
              end else begin
                i     <= '0;
                state <= S_ASCAN;
              end
            end else if (faddr_r < base_address) begin
              state <= S_DONE;
            end else begin
              state <= S_DIVH;
            end
          end
        end
        S_DIVH: begin
          if (div_done) begin
            head_r <= div_quot[START_W-1:0];
            if (!free_in_range) begin
              state <= S_DONE;
            end else if (count == RUNS_FULL) begin
              st_r  <= ST_TABLE_FULL;
              state <= S_DONE;
            end else begin
              i     <= '0;
              state <= S_FIND_RD;
            end
          end
        end
        S_ASCAN: begin
          if (i == count) begin
            st_r  <= ST_NO_SPACE;
            state <= S_DONE;
          end else begin
            state <= S_AEVAL;
          end
        end
        S_AEVAL: begin
          if (hit) begin
            prod <= 33'(mem_rdata.start) * 33'(eff_bb);
            if (drop_run) begin
              j     <= i + ONE;
              state <= S_SHDN_RD;
            end else begin
              state <= S_AADDR;
            end
          end else begin
            i     <= i + ONE;
            state <= S_ASCAN;
          end
        end
        S_SHDN_RD: begin
          if (j == count) begin
            count <= count - ONE;
            state <= S_AADDR;
          end else begin
            state <= S_SHDN_WR;
          end
        end
        S_SHDN_WR: begin
          j     <= j + ONE;
          state <= S_SHDN_RD;
        end
        S_AADDR: begin
          addr_r <= base_address + {15'd0, prod};
          state  <= S_DONE;
        end
        S_FIND_RD: begin
          if (i == count) begin
            pos   <= count;
            j     <= count;
            state <= S_SHUP;
          end else begin
            state <= S_FIND_EV;
          end
        end
        S_FIND_EV: begin
          if (mem_rdata.start > head_r) begin
            pos   <= i;
            j     <= count;
            state <= S_SHUP;
          end else begin
            i     <= i + ONE;
            state <= S_FIND_RD;
          end
        end
        S_SHUP: begin
          if (j == pos) begin
            count <= count + ONE;
            state <= S_MRG0;
          end else begin
            state <= S_SHUP_WR;
          end
        end
        S_SHUP_WR: begin
          j     <= j - ONE;
          state <= S_SHUP;
        end
        S_MRG0: begin
          state <= S_MRG1;
        end
        S_MRG1: begin
          cur   <= mem_rdata;
          w     <= '0;
          i     <= ONE;
          state <= S_MRG_RD;
        end
        S_MRG_RD: begin
          if (i == count) begin
            count <= w + ONE;
            state <= S_DONE;
          end else begin
            state <= S_MRG_EV;
          end
        end
        S_MRG_EV: begin
          // fold touching neighbors into the run in hand, else flush it
          if (adjacent) begin
            cur.len <= merged_len;
          end else begin
            cur <= mem_rdata;
            w   <= w + ONE;
          end
          i     <= i + ONE;
          state <= S_MRG_RD;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            status          <= st_r;
            granted_address <= addr_r;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_BYTES: begin
            block_bytes <= cfg_data[REG_W-1:0];
          end
          REG_TOTAL_BLOCKS: begin
            total_blocks <= cfg_data[REG_W-1:0];
            count        <= ONE;
          end
          REG_BASE_ADDRESS: begin
            base_address <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The table never holds more runs than the memory has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RUNS_FULL)
    else $error("run count exceeds table depth");

  // A failed request never reports an address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> granted_address == '0)
    else $error("address reported on failure");

  // A response is only raised from the completion step.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside completion");

  // A full table is only reported for a free request.
  a_full_on_free: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && st_r == ST_TABLE_FULL |-> cmd_r == CMD_FREE)
    else $error("table full reported for allocate");

endmodule
